// ===== hw/rtl/tmpg_pkg.sv =====
// ============================================================================
// tmpg_pkg - text mode pixel generator shared definitions
// Item and result types, command and register codes, reset palette.
// ============================================================================
package tmpg_pkg;

    // Command codes
    localparam logic [2:0] CMD_WRITE_CELL    = 3'd0;
    localparam logic [2:0] CMD_WRITE_GLYPH   = 3'd1;
    localparam logic [2:0] CMD_WRITE_PALETTE = 3'd2;
    localparam logic [2:0] CMD_RENDER        = 3'd3;
    localparam logic [2:0] CMD_FRAME_TICK    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_COLUMNS      = 3'd0;
    localparam logic [2:0] REG_CURSOR_COL   = 3'd1;
    localparam logic [2:0] REG_CURSOR_ROW   = 3'd2;
    localparam logic [2:0] REG_CURSOR_FIRST = 3'd3;
    localparam logic [2:0] REG_CURSOR_LAST  = 3'd4;
    localparam logic [2:0] REG_CURSOR_EN    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Default sizes
    localparam int DEF_TEXT_CELLS  = 2048;
    localparam int DEF_GLYPH_CHARS = 256;
    localparam int DEF_BLINK_TICKS = 30;

    // Cell arithmetic width: 127 rows * 127 columns + 127 fits, as does 16384
    localparam int CELL_W = 15;

    // Register reset values
    localparam logic [6:0] RST_COLUMNS      = 7'd80;
    localparam logic [3:0] RST_CURSOR_FIRST = 4'd14;
    localparam logic [3:0] RST_CURSOR_LAST  = 4'd15;

    localparam logic [31:0] EGA_COLORS [16] = '{
        32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
        32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
        32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
        32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
    };

    typedef struct packed {
        logic [2:0]  command;
        logic [10:0] cell_index;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [3:0]  glyph_line;
        logic [7:0]  glyph_bits;
        logic [3:0]  palette_index;
        logic [31:0] palette_color;
        logic [9:0]  pixel_x;
        logic [10:0] pixel_y;
    } tmpg_item_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        cursor_hit;
        logic        outside;
    } tmpg_result_t;

endpackage

// ===== hw/rtl/text_mode_pixel_generator_top.sv =====
// ============================================================================
// text_mode_pixel_generator_top - VGA-style text mode character generator
// Text, font and palette stores with a four-step in-order render pipeline.
// ============================================================================
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  item     | item_valid, item_ready, item             | in
//  result   | result_valid, result_ready, result       | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  One item per cycle is accepted while the pipeline is not stalled; a render
//  result passes registered address multiply, text read, font read and palette steps.
//  After reset a clearing pass zeroes the text and font memories, one entry a
//  cycle, over max(TEXT_CELLS, GLYPH_CHARS*16) addresses (4096 by default); no
//  item is accepted meanwhile, config writes are taken as ever.
//  A stalled result holds only the full pipeline steps behind it with no gap between.
//
module text_mode_pixel_generator_top #(
    parameter int TEXT_CELLS  = tmpg_pkg::DEF_TEXT_CELLS,
    parameter int GLYPH_CHARS = tmpg_pkg::DEF_GLYPH_CHARS,
    parameter int BLINK_TICKS = tmpg_pkg::DEF_BLINK_TICKS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  tmpg_pkg::tmpg_item_t                item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output tmpg_pkg::tmpg_result_t              result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tmpg_pkg::*;

    localparam int FONT_ROWS    = GLYPH_CHARS * 16;
    localparam int TEXT_ADDR_W  = $clog2(TEXT_CELLS);
    localparam int FONT_ADDR_W  = $clog2(FONT_ROWS);
    localparam int CLEAR_DEPTH  = (TEXT_CELLS > FONT_ROWS) ? TEXT_CELLS : FONT_ROWS;
    localparam int CLR_W        = $clog2(CLEAR_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0] columns_reg;
    logic [6:0] cursor_col_reg;
    logic [6:0] cursor_row_reg;
    logic [3:0] cursor_first_reg;
    logic [3:0] cursor_last_reg;
    logic       cursor_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg      <= RST_COLUMNS;
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            cursor_first_reg <= RST_CURSOR_FIRST;
            cursor_last_reg  <= RST_CURSOR_LAST;
            cursor_en_reg    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLUMNS:      columns_reg      <= cfg_data[6:0];
                REG_CURSOR_COL:   cursor_col_reg   <= cfg_data[6:0];
                REG_CURSOR_ROW:   cursor_row_reg   <= cfg_data[6:0];
                REG_CURSOR_FIRST: cursor_first_reg <= cfg_data[3:0];
                REG_CURSOR_LAST:  cursor_last_reg  <= cfg_data[3:0];
                REG_CURSOR_EN:    cursor_en_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_reg;
    logic             clr_text;
    logic             clr_font;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == CLR_W'(CLEAR_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clr_text = clr_busy_reg && ({{(32-CLR_W){1'b0}}, clr_reg} < 32'(TEXT_CELLS));
    assign clr_font = clr_busy_reg && ({{(32-CLR_W){1'b0}}, clr_reg} < 32'(FONT_ROWS));

    // ------------------------------------------------------------------
    // Pipeline handshake: each step moves when the one ahead is empty or moving
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic result_valid_reg;
    logic en2;
    logic en3;
    logic s3_fire;
    logic s3_render;
    logic accept;

    assign s3_fire    = s3_valid_reg && (!s3_render || !result_valid_reg || result_ready);
    assign en3        = !s3_valid_reg || s3_fire;
    assign en2        = !s2_valid_reg || en3;
    assign item_ready = !clr_busy_reg && (!s1_valid_reg || en2);
    assign accept     = item_valid && item_ready;

    // ------------------------------------------------------------------
    // Step 0: cell address, range checks, cursor match, blink counter
    // ------------------------------------------------------------------
    logic [6:0]        cx;
    logic [6:0]        cy;
    logic [13:0]       row_base;
    logic [CELL_W-1:0] cell_sum;
    logic              px_outside;
    logic              px_hit;
    logic              wr_cell_ok;
    logic [4:0]        blink_count_reg;
    logic              cursor_visible_reg;
    logic [4:0]        blink_next;

    assign cx         = item.pixel_x[9:3];
    assign cy         = item.pixel_y[10:4];
    assign row_base   = cy * columns_reg;
    assign cell_sum   = CELL_W'(row_base) + CELL_W'(cx);
    assign px_outside = (cx >= columns_reg) || (cell_sum >= CELL_W'(TEXT_CELLS));
    assign px_hit     = cursor_en_reg && cursor_visible_reg
                        && (cx == cursor_col_reg) && (cy == cursor_row_reg)
                        && (item.pixel_y[3:0] >= cursor_first_reg)
                        && (item.pixel_y[3:0] <= cursor_last_reg);
    assign wr_cell_ok = CELL_W'(item.cell_index) < CELL_W'(TEXT_CELLS);
    assign blink_next = blink_count_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_count_reg    <= '0;
            cursor_visible_reg <= 1'b0;
        end
        else if (accept && item.command == CMD_FRAME_TICK)
        begin
            if (blink_next >= 5'(BLINK_TICKS))
            begin
                blink_count_reg    <= '0;
                cursor_visible_reg <= !cursor_visible_reg;
            end
            else
            begin
                blink_count_reg <= blink_next;
            end
        end
    end

    tmpg_item_t        s1_item_reg;
    logic [CELL_W-1:0] s1_tidx_reg;
    logic              s1_tok_reg;
    logic              s1_outside_reg;
    logic              s1_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            if (item.command == CMD_WRITE_CELL)
            begin
                s1_tidx_reg <= CELL_W'(item.cell_index);
                s1_tok_reg  <= wr_cell_ok;
            end
            else
            begin
                s1_tidx_reg <= cell_sum;
                s1_tok_reg  <= !px_outside;
            end
            s1_outside_reg <= px_outside;
            s1_hit_reg     <= px_hit && !px_outside;
        end
    end

    // ------------------------------------------------------------------
    // Step 1: text memory, written and read as step 1 hands over
    // ------------------------------------------------------------------
    logic [15:0]            text_mem [TEXT_CELLS];
    logic [15:0]            txt_rdata_reg;
    logic                   txt_we;
    logic                   txt_re;
    logic [TEXT_ADDR_W-1:0] txt_waddr;
    logic [15:0]            txt_wdata;
    logic                   s1_move;

    assign s1_move   = en2 && s1_valid_reg;
    assign txt_we    = clr_text
                       || (s1_move && s1_item_reg.command == CMD_WRITE_CELL && s1_tok_reg);
    assign txt_re    = s1_move && s1_item_reg.command == CMD_RENDER && s1_tok_reg;
    assign txt_waddr = clr_busy_reg ? clr_reg[TEXT_ADDR_W-1:0] : s1_tidx_reg[TEXT_ADDR_W-1:0];
    assign txt_wdata = clr_busy_reg ? 16'd0 : {s1_item_reg.attribute, s1_item_reg.char_code};

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            text_mem[txt_waddr] <= txt_wdata;
        end
        if (txt_re)
        begin
            txt_rdata_reg <= text_mem[s1_tidx_reg[TEXT_ADDR_W-1:0]];
        end
    end

    tmpg_item_t s2_item_reg;
    logic       s2_outside_reg;
    logic       s2_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_item_reg    <= s1_item_reg;
            s2_outside_reg <= s1_outside_reg;
            s2_hit_reg     <= s1_hit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Step 2: font memory
    // ------------------------------------------------------------------
    logic [7:0]             font_mem [FONT_ROWS];
    logic [7:0]             font_rdata_reg;
    logic                   s2_render;
    logic [7:0]             g_char;
    logic [3:0]             g_line;
    logic                   g_ok;
    logic [12:0]            g_addr;
    logic                   font_we;
    logic                   font_re;
    logic [FONT_ADDR_W-1:0] font_waddr;
    logic [7:0]             font_wdata;
    logic                   s2_move;

    assign s2_render  = s2_item_reg.command == CMD_RENDER;
    assign g_char     = s2_render ? txt_rdata_reg[7:0] : s2_item_reg.char_code;
    assign g_line     = s2_render ? s2_item_reg.pixel_y[3:0] : s2_item_reg.glyph_line;
    assign g_ok       = {2'b00, g_char} < 10'(GLYPH_CHARS);
    assign g_addr     = {1'b0, g_char, g_line};
    assign s2_move    = en3 && s2_valid_reg;
    assign font_we    = clr_font
                        || (s2_move && s2_item_reg.command == CMD_WRITE_GLYPH && g_ok);
    assign font_re    = s2_move && s2_render && g_ok && !s2_outside_reg;
    assign font_waddr = clr_busy_reg ? clr_reg[FONT_ADDR_W-1:0] : g_addr[FONT_ADDR_W-1:0];
    assign font_wdata = clr_busy_reg ? 8'd0 : s2_item_reg.glyph_bits;

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[font_waddr] <= font_wdata;
        end
        if (font_re)
        begin
            font_rdata_reg <= font_mem[g_addr[FONT_ADDR_W-1:0]];
        end
    end

    tmpg_item_t s3_item_reg;
    logic       s3_outside_reg;
    logic       s3_hit_reg;
    logic       s3_gok_reg;
    logic [7:0] s3_attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_item_reg    <= s2_item_reg;
            s3_outside_reg <= s2_outside_reg;
            s3_hit_reg     <= s2_hit_reg;
            s3_gok_reg     <= g_ok;
            s3_attr_reg    <= txt_rdata_reg[15:8];
        end
    end

    // ------------------------------------------------------------------
    // Step 3: pixel select, cursor invert, palette lookup and write
    // ------------------------------------------------------------------
    logic [31:0] pal_reg [16];
    logic [2:0]  fx;
    logic        pix_on;
    logic [3:0]  pal_idx;

    assign s3_render = s3_item_reg.command == CMD_RENDER;
    assign fx        = s3_item_reg.pixel_x[2:0];
    assign pix_on    = (s3_gok_reg && font_rdata_reg[3'd7 - fx]) ^ s3_hit_reg;
    assign pal_idx   = pix_on ? s3_attr_reg[3:0] : {1'b0, s3_attr_reg[6:4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pal_reg[i] <= EGA_COLORS[i];
            end
        end
        else if (s3_fire && s3_item_reg.command == CMD_WRITE_PALETTE)
        begin
            pal_reg[s3_item_reg.palette_index] <= s3_item_reg.palette_color;
        end
    end

    // Output register: load a finished render, drop it once taken
    tmpg_result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s3_fire && s3_render)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_fire && s3_render)
        begin
            result_reg.pixel_color <= s3_outside_reg ? 32'd0 : pal_reg[pal_idx];
            result_reg.cursor_hit  <= s3_hit_reg;
            result_reg.outside     <= s3_outside_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - text mode pixel generator
// Drives cell, glyph, palette, render and frame tick items through the block
// with random gaps on both channels, predicts each rendered pixel from a copy
// of the text, font and palette stores, and checks every result in order.
// ============================================================================
module testbench;

    import tmpg_pkg::*;

    localparam int TEXT_CELLS       = DEF_TEXT_CELLS;
    localparam int GLYPH_ROWS       = DEF_GLYPH_CHARS * 16;
    localparam int BLINK_TICKS      = DEF_BLINK_TICKS;
    localparam int RESET_CYCLES     = 10;
    // Render pipeline is four deep; leave margin for writes still in flight
    localparam int DRAIN_CYCLES     = 12;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CHUNKS           = 9;
    localparam int CHUNK_ITEMS      = 200;
    // Clearing pass plus ~1900 items, many times over
    localparam int CYCLE_LIMIT      = 400000;

    // Commands the block must ignore
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    // ------------------------------------------------------------------------
    // Block connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_ready;
    tmpg_item_t   item         = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    tmpg_result_t result;
    logic         cfg_valid    = 1'b0;
    logic         cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    text_mode_pixel_generator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the display registers and stores
    // ------------------------------------------------------------------------
    logic [6:0]  cfg_columns;
    logic [6:0]  cfg_cursor_col;
    logic [6:0]  cfg_cursor_row;
    logic [3:0]  cfg_cursor_first;
    logic [3:0]  cfg_cursor_last;
    logic        cfg_cursor_en;

    logic [15:0] text_mem [TEXT_CELLS];
    logic [7:0]  font_mem [GLYPH_ROWS];
    logic [31:0] palette_mem [16];
    logic [4:0]  blink_ticks;
    logic        cursor_shown;

    tmpg_item_t   item_fifo[$];
    tmpg_result_t expected_pixels[$];

    // Idle chances in percent, set per phase by the stimulus
    int   send_idle_pct = 7;
    int   recv_idle_pct = 72;
    logic long_hold     = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    logic took_item     = 1'b0;

    int   error_count    = 0;
    int   items_made     = 0;
    int   items_accepted = 0;
    int   pixels_seen    = 0;
    int   hits_seen      = 0;
    int   outside_seen   = 0;
    int   settings_used  = 0;
    int   cycle_count    = 0;

    // Apply one accepted item to the predictor; a render queues its pixel
    task automatic predict_pixel_item(input tmpg_item_t it);
        logic [6:0]   cell_x;
        logic [6:0]   cell_y;
        logic [2:0]   fine_x;
        logic [3:0]   fine_y;
        int           cell_idx;
        logic [15:0]  entry;
        logic [7:0]   glyph_row;
        logic         lit;
        logic         hit;
        logic [3:0]   color_idx;
        tmpg_result_t px;
        case (it.command)
            CMD_WRITE_CELL:    text_mem[it.cell_index] = {it.attribute, it.char_code};
            CMD_WRITE_GLYPH:   font_mem[{it.char_code, it.glyph_line}] = it.glyph_bits;
            CMD_WRITE_PALETTE: palette_mem[it.palette_index] = it.palette_color;
            CMD_FRAME_TICK:
            begin
                blink_ticks = blink_ticks + 5'd1;
                if (blink_ticks >= BLINK_TICKS)
                begin
                    cursor_shown = ~cursor_shown;
                    blink_ticks  = '0;
                end
            end
            CMD_RENDER:
            begin
                cell_x   = it.pixel_x[9:3];
                cell_y   = it.pixel_y[10:4];
                fine_x   = it.pixel_x[2:0];
                fine_y   = it.pixel_y[3:0];
                cell_idx = int'(cell_y) * int'(cfg_columns) + int'(cell_x);
                if (cell_x >= cfg_columns || cell_idx >= TEXT_CELLS)
                begin
                    px.pixel_color = '0;
                    px.cursor_hit  = 1'b0;
                    px.outside     = 1'b1;
                end
                else
                begin
                    entry     = text_mem[cell_idx];
                    glyph_row = font_mem[{entry[7:0], fine_y}];
                    lit       = glyph_row[3'd7 - fine_x];
                    hit       = cfg_cursor_en && cursor_shown &&
                                cell_x == cfg_cursor_col && cell_y == cfg_cursor_row &&
                                fine_y >= cfg_cursor_first && fine_y <= cfg_cursor_last;
                    lit       = lit ^ hit;
                    // Attribute bit 7 plays no part
                    color_idx = lit ? entry[11:8] : {1'b0, entry[14:12]};
                    px.pixel_color = palette_mem[color_idx];
                    px.cursor_hit  = hit;
                    px.outside     = 1'b0;
                end
                expected_pixels.push_back(px);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued items at the falling edge, hold until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && !took_item)
            ; // hold the item until the block takes it
        else if (item_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            item       <= item_fifo.pop_front();
            item_valid <= 1'b1;
        end
        else
            item_valid <= 1'b0;
    end

    // Record each accepted item and predict what it causes
    always @(posedge clk)
    begin
        took_item <= item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            predict_pixel_item(item);
            items_accepted++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off to back up the pipeline
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (long_hold && !hold_done)
        begin
            result_ready <= 1'b0;
            hold_left    <= LONG_HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: compare each taken result with the oldest expected pixel
    always @(posedge clk)
    begin
        tmpg_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            pixels_seen++;
            if (result.cursor_hit === 1'b1)
                hits_seen++;
            if (result.outside === 1'b1)
                outside_seen++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.pixel_color !== want.pixel_color)
                begin
                    $display("%0t: pixel_color expected %h actual %h",
                             $time, want.pixel_color, result.pixel_color);
                    error_count++;
                end
                if (result.cursor_hit !== want.cursor_hit)
                begin
                    $display("%0t: cursor_hit expected %b actual %b",
                             $time, want.cursor_hit, result.cursor_hit);
                    error_count++;
                end
                if (result.outside !== want.outside)
                begin
                    $display("%0t: outside expected %b actual %b",
                             $time, want.outside, result.outside);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it stalls far past any correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d pixels pending", $time, expected_pixels.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Fill every field at random so that unused bits toggle too
    function automatic tmpg_item_t make_item(input logic [2:0] cmd);
        tmpg_item_t it;
        it.command       = cmd;
        it.cell_index    = 11'($urandom);
        it.char_code     = 8'($urandom);
        it.attribute     = 8'($urandom);
        it.glyph_line    = 4'($urandom);
        it.glyph_bits    = 8'($urandom);
        it.palette_index = 4'($urandom);
        it.palette_color = $urandom;
        it.pixel_x       = 10'($urandom);
        it.pixel_y       = 11'($urandom);
        return it;
    endfunction

    task automatic queue_item(input tmpg_item_t it);
        item_fifo.push_back(it);
        if (it.command <= CMD_FRAME_TICK)
            items_made++;
    endtask

    task automatic queue_render(input int x, input int y);
        tmpg_item_t it;
        it         = make_item(CMD_RENDER);
        it.pixel_x = 10'(x);
        it.pixel_y = 11'(y);
        queue_item(it);
    endtask

    // Pick a text cell, often the cursor cell, mostly inside the screen
    task automatic pick_cell(output int cx, output int cy);
        int rows;
        if ($urandom_range(0, 99) < 30)
        begin
            cx = int'(cfg_cursor_col);
            cy = int'(cfg_cursor_row);
        end
        else
        begin
            if (cfg_columns == 0 || $urandom_range(0, 99) < 8)
                cx = $urandom_range(0, 127);
            else
                cx = $urandom_range(0, cfg_columns - 1);
            rows = (cfg_columns == 0) ? 127 : TEXT_CELLS / int'(cfg_columns);
            if (rows > 127)
                rows = 127;
            cy = $urandom_range(0, rows);
        end
    endtask

    // Wait until every item is taken and every pixel is back, then settle
    task automatic wait_until_drained();
        @(posedge clk);
        while (item_fifo.size() != 0 || item_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_COLUMNS:      cfg_columns      = data[6:0];
            REG_CURSOR_COL:   cfg_cursor_col   = data[6:0];
            REG_CURSOR_ROW:   cfg_cursor_row   = data[6:0];
            REG_CURSOR_FIRST: cfg_cursor_first = data[3:0];
            REG_CURSOR_LAST:  cfg_cursor_last  = data[3:0];
            REG_CURSOR_EN:    cfg_cursor_en    = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reprogram all display registers once the block is idle
    task automatic program_display(input logic [7:0] cols, input logic [7:0] ccol,
                                   input logic [7:0] crow, input logic [7:0] first,
                                   input logic [7:0] last, input logic [7:0] en);
        wait_until_drained();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_CURSOR_COL, ccol);
        write_reg(REG_CURSOR_ROW, crow);
        write_reg(REG_CURSOR_FIRST, first);
        write_reg(REG_CURSOR_LAST, last);
        write_reg(REG_CURSOR_EN, en);
        settings_used++;
    endtask

    // Random mix; most of it writes a cell and its glyph, then renders inside it
    task automatic queue_random_items(input int count);
        int         target;
        int         roll;
        int         cx;
        int         cy;
        int         line;
        tmpg_item_t it;
        target = items_made + count;
        while (items_made < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                pick_cell(cx, cy);
                it            = make_item(CMD_WRITE_CELL);
                it.cell_index = 11'(cy * int'(cfg_columns) + cx);
                queue_item(it);
                it.command    = CMD_WRITE_GLYPH;
                line          = $urandom_range(0, 15);
                repeat ($urandom_range(1, 3))
                begin
                    line          = $urandom_range(0, 15);
                    it.glyph_line = 4'(line);
                    case ($urandom_range(0, 3))
                        0:       it.glyph_bits = 8'h00;
                        1:       it.glyph_bits = 8'hFF;
                        default: it.glyph_bits = 8'($urandom);
                    endcase
                    queue_item(it);
                end
                repeat ($urandom_range(2, 4))
                    queue_render(cx * 8 + $urandom_range(0, 7),
                                 cy * 16 + (($urandom_range(0, 1) == 0) ? line
                                                                       : $urandom_range(0, 15)));
            end
            else if (roll < 57)
            begin
                // Bursts of frame ticks drive the cursor blink through its toggles
                repeat ($urandom_range(1, 12))
                    queue_item(make_item(CMD_FRAME_TICK));
            end
            else if (roll < 67)
            begin
                it = make_item(CMD_WRITE_PALETTE);
                case ($urandom_range(0, 5))
                    0:       it.palette_color = 32'h0000_0000;
                    1:       it.palette_color = 32'hFFFF_FFFF;
                    default: ;
                endcase
                queue_item(it);
            end
            else if (roll < 85)
                queue_item(make_item(CMD_RENDER));
            else if (roll < 97)
                queue_item(make_item(($urandom_range(0, 1) == 0) ? CMD_WRITE_CELL
                                                                  : CMD_WRITE_GLYPH));
            else
                queue_item(make_item(3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED))));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tmpg_item_t it;
        int         cols;
        int         first;
        int         rows;

        // Predictor starts from the reset state of the block
        cfg_columns      = RST_COLUMNS;
        cfg_cursor_col   = '0;
        cfg_cursor_row   = '0;
        cfg_cursor_first = RST_CURSOR_FIRST;
        cfg_cursor_last  = RST_CURSOR_LAST;
        cfg_cursor_en    = 1'b1;
        for (int i = 0; i < TEXT_CELLS; i++)
            text_mem[i] = '0;
        for (int i = 0; i < GLYPH_ROWS; i++)
            font_mem[i] = '0;
        for (int i = 0; i < 16; i++)
            palette_mem[i] = EGA_COLORS[i];
        blink_ticks  = '0;
        cursor_shown = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset settings: cleared stores, store edges, palette
        queue_render(0, 0);
        it            = make_item(CMD_WRITE_CELL);
        it.cell_index = 11'd0;
        it.char_code  = 8'hFF;
        it.attribute  = 8'hFF;
        queue_item(it);
        it            = make_item(CMD_WRITE_GLYPH);
        it.char_code  = 8'hFF;
        it.glyph_line = 4'd0;
        it.glyph_bits = 8'h80;
        queue_item(it);
        it.glyph_line = 4'd15;
        it.glyph_bits = 8'h01;
        queue_item(it);
        queue_render(0, 0);
        queue_render(1, 0);
        queue_render(7, 15);
        it               = make_item(CMD_WRITE_PALETTE);
        it.palette_index = 4'd15;
        it.palette_color = 32'h1234_5678;
        queue_item(it);
        it.palette_index = 4'd7;
        it.palette_color = 32'hFFFF_FFFF;
        queue_item(it);
        it.palette_index = 4'd0;
        it.palette_color = 32'h0000_0000;
        queue_item(it);
        queue_render(0, 0);
        queue_render(1, 0);
        // Column beyond the row, then a row beyond the text store
        queue_render(1023, 2047);
        queue_render(0, 2047);
        queue_render(639, 400);
        queue_render(639, 399);
        // Last cell of the text store
        it            = make_item(CMD_WRITE_CELL);
        it.cell_index = 11'd2047;
        it.char_code  = 8'h01;
        it.attribute  = 8'h70;
        queue_item(it);
        it            = make_item(CMD_WRITE_GLYPH);
        it.char_code  = 8'h01;
        it.glyph_line = 4'd7;
        it.glyph_bits = 8'hAA;
        queue_item(it);
        queue_render(376, 407);
        queue_render(377, 407);
        // Unknown commands must leave no trace
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
            queue_item(make_item(3'(c)));
        queue_item(make_item(CMD_FRAME_TICK));

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            case (chunk)
                0: program_display(8'd80, 8'd5, 8'd3, 8'd0, 8'd15, 8'd1);
                1: program_display(8'd1, 8'd0, 8'd0, 8'd15, 8'd15, 8'd1);
                // Widest rows, cursor off, first line past last line
                3: program_display(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFE);
                // Columns of zero put every pixel outside
                5: program_display(8'h80, 8'd2, 8'd2, 8'd0, 8'd15, 8'd1);
                8: program_display({1'b0, RST_COLUMNS}, 8'd0, 8'd0,
                                   {4'd0, RST_CURSOR_FIRST}, {4'd0, RST_CURSOR_LAST}, 8'd1);
                default:
                begin
                    cols  = $urandom_range(1, 80);
                    rows  = TEXT_CELLS / cols - 1;
                    if (rows > 127)
                        rows = 127;
                    first = $urandom_range(0, 15);
                    program_display(8'(cols), 8'($urandom_range(0, cols - 1)),
                                    8'($urandom_range(0, rows)),
                                    8'(first),
                                    ($urandom_range(0, 99) < 85) ? 8'($urandom_range(first, 15))
                                                                 : 8'($urandom_range(0, 15)),
                                    ($urandom_range(0, 99) < 85) ? 8'd1 : 8'd0);
                end
            endcase

            // Sender light and receiver heavy, then swapped, then no idling
            if (chunk < 3)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 72;
            end
            else if (chunk < 6)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Back up the pipeline once while the sender keeps offering items
            if (chunk == 7)
                long_hold = 1'b1;
            queue_random_items(CHUNK_ITEMS);
        end

        wait_until_drained();
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
            error_count++;
        end

        $display("covered %0d items and %0d pixels (%0d under the cursor, %0d outside)",
                 items_accepted, pixels_seen, hits_seen, outside_seen);
        $display("across %0d register settings, with %0d mismatches",
                 settings_used, error_count);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
